[rtl/core/updt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// updt_pkg: types and codes shared by the endpoint table modules
// Commands, status codes, request and result structs, controller states and
// the command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package updt_pkg;

  typedef enum logic [2:0] {
    CMD_REGISTER = 3'd0,
    CMD_RELEASE  = 3'd1,
    CMD_ARRIVAL  = 3'd2,
    CMD_RX_EXACT = 3'd3,
    CMD_RX_ANY   = 3'd4
  } cmd_code_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NO_MATCH  = 3'd3;
  localparam logic [2:0] ST_DROPPED   = 3'd4;
  localparam logic [2:0] ST_WAITING   = 3'd5;
  localparam logic [2:0] ST_FREED     = 3'd6;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] remote_ip;
    logic [15:0] remote_port;
    logic [15:0] local_port;
    logic [7:0]  packet_handle;
    logic [7:0]  requester_id;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  slot_index;
    logic [7:0]  out_handle;
    logic [31:0] sender_ip;
    logic [15:0] sender_port;
    logic        wake_valid;
    logic [7:0]  wake_id;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN2,
    S_ACT,
    S_DRAIN,
    S_FETCH,
    S_OUT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_clr;   // restart search
    logic scan_step;  // examine one entry
    logic pass2;      // second pass of register search
    logic act;        // apply the command on the found entry
    logic pop;        // start a ring read for drain or receive
    logic fetch;      // form result from ring read
    logic fin;        // form final release result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic drain_more;
    logic need_read;
    logic ignored;
    logic rel_hit;    // release found its entry
    logic draining;   // release drain in progress
  } dp_stat_t;

endpackage

[rtl/core/updt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// updt_ctrl: command sequencer
// Steps the datapath through search, action, drain and result hand-off.
// ----------------------------------------------------------------------------
module updt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   out_free,
  output logic                   out_load,
  input  updt_pkg::dp_stat_t     st,
  input  logic [2:0]             cmd,
  output updt_pkg::dp_cmd_t      dc
);

  updt_pkg::ctrl_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= updt_pkg::S_IDLE;
    else     state <= state_next;
  end

  // next state and commands
  always_comb begin
    state_next = state;
    dc = '0;
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state)
      updt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dc.load = 1'b1;
          dc.scan_clr = 1'b1;
          state_next = updt_pkg::S_SCAN;
        end
      end
      updt_pkg::S_SCAN: begin
        if (st.ignored) state_next = updt_pkg::S_IDLE;
        else begin
          dc.scan_step = 1'b1;
          if (st.scan_done) begin
            if (cmd == 3'(updt_pkg::CMD_REGISTER)) state_next = updt_pkg::S_SCAN2;
            else state_next = updt_pkg::S_ACT;
          end
        end
      end
      updt_pkg::S_SCAN2: begin
        dc.pass2 = 1'b1;
        dc.scan_step = 1'b1;
        if (st.scan_done) state_next = updt_pkg::S_ACT;
      end
      updt_pkg::S_ACT: begin
        if (out_free) begin
          dc.act = 1'b1;
          if (st.rel_hit) begin
            state_next = updt_pkg::S_DRAIN;
          end else if (st.need_read) begin
            dc.pop = 1'b1;
            state_next = updt_pkg::S_FETCH;
          end else begin
            out_load = 1'b1;
            state_next = updt_pkg::S_IDLE;
          end
        end
      end
      updt_pkg::S_FETCH: begin
        state_next = updt_pkg::S_OUT;
      end
      updt_pkg::S_OUT: begin
        if (out_free) begin
          dc.fetch = 1'b1;
          out_load = 1'b1;
          state_next = updt_pkg::S_DRAIN;
        end
      end
      updt_pkg::S_DRAIN: begin
        if (st.drain_more) begin
          dc.pop = 1'b1;
          state_next = updt_pkg::S_FETCH;
        end else if (!st.draining) begin
          state_next = updt_pkg::S_IDLE;
        end else if (out_free) begin
          dc.fin = 1'b1;
          out_load = 1'b1;
          state_next = updt_pkg::S_IDLE;
        end
      end
      default: state_next = updt_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/core/updt_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// updt_dp: endpoint table and packet rings
// Holds the entry keys and queue state, searches one entry per cycle and keeps
// the queued handles with their senders in one ring memory.
// ----------------------------------------------------------------------------
module updt_dp #(
  parameter int SLOTS        = 16,
  parameter int QUEUE_DEPTH  = 8,
  parameter int HANDLE_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  updt_pkg::request_t   req_in,
  input  updt_pkg::dp_cmd_t    dc,
  output updt_pkg::dp_stat_t   st,
  output logic [2:0]           cmd,
  output updt_pkg::result_t    res
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int MD = SLOTS * QUEUE_DEPTH;
  localparam int MW = (MD > 1) ? $clog2(MD) : 1;
  localparam int IW = $clog2(SLOTS + 1);

  updt_pkg::request_t req;

  // entry state
  logic [SLOTS-1:0] in_use, waiting;
  logic [15:0] e_lp [SLOTS];
  logic [15:0] e_rp [SLOTS];
  logic [31:0] e_ip [SLOTS];
  logic [7:0]  w_id [SLOTS];
  logic [CW-1:0] q_cnt [SLOTS];
  logic [QW-1:0] q_head [SLOTS];
  logic [QW-1:0] q_tail [SLOTS];

  // ring memory
  logic [55:0] ring [MD];
  logic [55:0] ring_rd;

  // search state
  logic [IW-1:0] idx;
  logic          found, seen;
  logic [SW-1:0] hit, first;
  logic [SW-1:0] cur;
  logic          drain;

  assign cur = idx[SW-1:0];
  assign cmd = req.command;

  logic exact, wild, anyk, room, match;
  always_comb begin
    exact = e_ip[cur] == req.remote_ip && e_rp[cur] == req.remote_port &&
            e_lp[cur] == req.local_port;
    wild  = e_lp[cur] == req.local_port &&
            (e_rp[cur] == 16'd0 || e_rp[cur] == req.remote_port) &&
            (e_ip[cur] == 32'd0 || e_ip[cur] == req.remote_ip);
    anyk  = e_ip[cur] == 32'd0 && e_lp[cur] == req.local_port;
    room  = q_cnt[cur] < CW'(QUEUE_DEPTH);
    case (req.command)
      3'(updt_pkg::CMD_REGISTER): match = dc.pass2 ? !in_use[cur] : in_use[cur] && exact;
      3'(updt_pkg::CMD_RELEASE):  match = in_use[cur] && !waiting[cur] && exact;
      3'(updt_pkg::CMD_ARRIVAL):  match = in_use[cur] && wild && room;
      3'(updt_pkg::CMD_RX_EXACT): match = in_use[cur] && exact;
      3'(updt_pkg::CMD_RX_ANY):   match = in_use[cur] && anyk;
      default:                    match = 1'b0;
    endcase
  end

  logic bad_handle;
  assign bad_handle = 32'(req.packet_handle) >= 32'(HANDLE_COUNT);

  assign st.ignored   = req.command > 3'(updt_pkg::CMD_RX_ANY);
  assign st.scan_done = found || idx == IW'(SLOTS - 1) || match;
  assign st.drain_more = drain && q_cnt[hit] != '0;
  assign st.need_read = (req.command == 3'(updt_pkg::CMD_RX_EXACT) ||
                         req.command == 3'(updt_pkg::CMD_RX_ANY)) && found &&
                        q_cnt[hit] != '0 && !drain;
  assign st.rel_hit   = req.command == 3'(updt_pkg::CMD_RELEASE) && found;
  assign st.draining  = drain;

  logic [MW-1:0] rd_addr, wr_addr;
  assign rd_addr = MW'(32'(hit) * QUEUE_DEPTH + 32'(q_head[hit]));
  assign wr_addr = MW'(32'(hit) * QUEUE_DEPTH + 32'(q_tail[hit]));

  logic do_reg, do_rel, do_arr, do_rx, arr_ok;
  always_comb begin
    do_reg = dc.act && req.command == 3'(updt_pkg::CMD_REGISTER);
    do_rel = dc.act && req.command == 3'(updt_pkg::CMD_RELEASE) && found;
    do_arr = dc.act && req.command == 3'(updt_pkg::CMD_ARRIVAL);
    do_rx  = dc.act && (req.command == 3'(updt_pkg::CMD_RX_EXACT) ||
                        req.command == 3'(updt_pkg::CMD_RX_ANY));
    arr_ok = do_arr && found && !bad_handle;
  end

  // ring write and registered read of the head on a pop
  always_ff @(posedge clk) begin
    if (arr_ok) ring[wr_addr] <= {req.packet_handle, req.remote_ip, req.remote_port};
    if (dc.pop) ring_rd <= ring[rd_addr];
  end

  // search sweep and request capture
  always_ff @(posedge clk) begin
    if (dc.load) req <= req_in;
    if (rst) begin
      idx <= '0; found <= 1'b0; seen <= 1'b0; drain <= 1'b0;
      hit <= '0; first <= '0;
    end else if (dc.scan_clr) begin
      idx <= '0; found <= 1'b0; seen <= 1'b0; drain <= 1'b0;
    end else if (dc.scan_step) begin
      if (st.scan_done && !dc.pass2 && req.command == 3'(updt_pkg::CMD_REGISTER) &&
          !(match && !found) && !found) begin
        idx <= '0;
      end else if (!found && idx != IW'(SLOTS - 1)) idx <= idx + 1'b1;
      if (!found && match) begin
        found <= 1'b1; hit <= cur;
      end
      if (req.command == 3'(updt_pkg::CMD_ARRIVAL) && !found && !seen &&
          in_use[cur] && wild) begin
        seen <= 1'b1; first <= cur;
      end
    end else if (do_rel) begin
      drain <= 1'b1;
    end else if (dc.fin) begin
      drain <= 1'b0;
    end
  end

  // duplicate flag for register: found in pass one
  logic dup;
  always_ff @(posedge clk) begin
    if (rst || dc.scan_clr) dup <= 1'b0;
    else if (dc.scan_step && !dc.pass2 && !found && match) dup <= 1'b1;
    else if (dc.scan_step && !dc.pass2 && st.scan_done && !match && !found)
      dup <= 1'b0;
  end

  // table state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
      waiting <= '0;
      for (int k = 0; k < SLOTS; k++) begin
        q_cnt[k] <= '0; q_head[k] <= '0; q_tail[k] <= '0;
      end
    end else begin
      if (do_reg && found && !dup) begin
        in_use[hit] <= 1'b1;
        e_lp[hit] <= req.local_port;
        e_rp[hit] <= req.remote_port;
        e_ip[hit] <= req.remote_ip;
        q_cnt[hit] <= '0; q_head[hit] <= '0; q_tail[hit] <= '0;
        waiting[hit] <= 1'b0;
      end
      if (arr_ok) begin
        q_tail[hit] <= (32'(q_tail[hit]) == QUEUE_DEPTH - 1) ? '0 : q_tail[hit] + 1'b1;
        q_cnt[hit] <= q_cnt[hit] + 1'b1;
        waiting[hit] <= 1'b0;
      end
      if (do_rx && found && q_cnt[hit] == '0) begin
        waiting[hit] <= 1'b1;
        w_id[hit] <= req.requester_id;
      end
      if (dc.pop) begin
        q_head[hit] <= (32'(q_head[hit]) == QUEUE_DEPTH - 1) ? '0 : q_head[hit] + 1'b1;
        q_cnt[hit] <= q_cnt[hit] - 1'b1;
      end
      if (dc.fin) in_use[hit] <= 1'b0;
    end
  end

  // result forming
  always_comb begin
    res = '0;
    res.last = 1'b1;
    if (dc.fetch) begin
      res.status = drain ? updt_pkg::ST_FREED : updt_pkg::ST_OK;
      res.slot_index = 4'(hit);
      {res.out_handle, res.sender_ip, res.sender_port} = ring_rd;
      res.last = !drain;
    end else if (dc.fin) begin
      res.status = updt_pkg::ST_OK;
      res.slot_index = 4'(hit);
    end else begin
      case (req.command)
        3'(updt_pkg::CMD_REGISTER): begin
          if (dup) begin
            res.status = updt_pkg::ST_DUPLICATE; res.slot_index = 4'(hit);
          end else if (found) begin
            res.status = updt_pkg::ST_OK; res.slot_index = 4'(hit);
          end else res.status = updt_pkg::ST_FULL;
        end
        3'(updt_pkg::CMD_RELEASE): res.status = updt_pkg::ST_NO_MATCH;
        3'(updt_pkg::CMD_ARRIVAL): begin
          res.out_handle = req.packet_handle;
          if (bad_handle) res.status = updt_pkg::ST_NO_MATCH;
          else if (found) begin
            res.status = updt_pkg::ST_OK;
            res.slot_index = 4'(hit);
            res.wake_valid = waiting[hit];
            res.wake_id = waiting[hit] ? w_id[hit] : 8'd0;
          end else if (seen) begin
            res.status = updt_pkg::ST_DROPPED; res.slot_index = 4'(first);
          end else res.status = updt_pkg::ST_NO_MATCH;
        end
        default: begin
          if (found) begin
            res.status = updt_pkg::ST_WAITING; res.slot_index = 4'(hit);
          end else res.status = updt_pkg::ST_NO_MATCH;
        end
      endcase
    end
  end

endmodule

[rtl/core/udp_port_demux_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_port_demux_table: UDP endpoint table with per-entry packet queues
// Register, release, arrival and receive commands over a table of endpoints.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   request   req_valid/req_stall  updt_pkg::request_t
//   result    res_valid/res_stall  updt_pkg::result_t
//
// Between accepts a command passes through the idle state, the sequential
// search at one entry per cycle and the action state; register sweeps the
// table twice. A receive that returns a handle adds a ring read; a release
// adds a ring read per drained handle and one final result.
// Reset clears entry use, waiting and queue counters; no clearing pass.
// A result waits in the output register while res_stall is high.
module udp_port_demux_table #(
  parameter int SLOTS        = 16,
  parameter int QUEUE_DEPTH  = 8,
  parameter int HANDLE_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  updt_pkg::request_t req_data,
  output logic               res_valid,
  input  logic               res_stall,
  output updt_pkg::result_t  res_data
);

  updt_pkg::dp_cmd_t  dc;
  updt_pkg::dp_stat_t st;
  updt_pkg::result_t  res;
  logic [2:0] cmd;
  logic out_free, out_load;

  assign out_free = !res_valid || !res_stall;

  updt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req_valid), .in_stall(req_stall),
    .out_free(out_free), .out_load(out_load), .st(st), .cmd(cmd), .dc(dc)
  );

  updt_dp #(.SLOTS(SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH), .HANDLE_COUNT(HANDLE_COUNT)) u_dp (
    .clk(clk), .rst(rst), .req_in(req_data), .dc(dc), .st(st), .cmd(cmd), .res(res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (out_load) res_valid <= 1'b1;
    else if (!res_stall) res_valid <= 1'b0;
    if (out_load) res_data <= res;
  end

endmodule

[rtl/core/updt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// updt_checker: port checks for the endpoint table
// Watches the request and result ports over time.
// ----------------------------------------------------------------------------
module updt_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               res_valid,
  input logic               res_stall,
  input updt_pkg::result_t  res_data
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("result changed under stall");

  // a new request is not taken the cycle after one was
  a_gap: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken back to back");

  // status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.status <= updt_pkg::ST_FREED)
    else $error("bad status");

  // freed results are never final
  a_freed: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.status == updt_pkg::ST_FREED |-> !res_data.last)
    else $error("freed result marked last");

endmodule

bind udp_port_demux_table updt_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
  .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
);

[dv/udp_port_demux_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_port_demux_table_test: self-checking bench for the endpoint table
// A short table of directed requests, then random register, release, arrival,
// receive and unused-code traffic over a small endpoint key pool. Each accepted
// request is run through a local copy of the table and queues; results are
// compared field by field in order, with random idling on both channels and
// one long receiver hold-off so that the block fills and stalls its input.
// ----------------------------------------------------------------------------
module udp_port_demux_table_test;

  localparam int SLOTS        = 16;
  localparam int QUEUE_DEPTH  = 8;
  localparam int HANDLE_COUNT = 256;
  localparam int RANDOM_ITEMS = 340;
  localparam int KEY_POOL     = 24;
  localparam int QUIET_FROM   = 290;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct {
    updt_pkg::request_t req;
    bit                 typed;
    updt_pkg::result_t  res;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  updt_pkg::request_t req_data = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  updt_pkg::result_t  res_data;

  int  failures = 0;
  bit  quiet_phase = 1'b0;
  bit  hold_off_now = 1'b0;

  // local copy of the endpoint table
  bit          ep_used [SLOTS];
  logic [15:0] ep_lport [SLOTS];
  logic [15:0] ep_rport [SLOTS];
  logic [31:0] ep_rip [SLOTS];
  int          ring_count [SLOTS];
  int          ring_head [SLOTS];
  int          ring_tail [SLOTS];
  bit          ep_waiting [SLOTS];
  logic [7:0]  ep_waiter [SLOTS];
  logic [7:0]  ring_handle [SLOTS][QUEUE_DEPTH];
  logic [31:0] ring_ip [SLOTS][QUEUE_DEPTH];
  logic [15:0] ring_port [SLOTS][QUEUE_DEPTH];

  updt_pkg::result_t pending_results[$];
  stim_row_t stim_table[$];

  logic [31:0] pool_ip [KEY_POOL];
  logic [15:0] pool_rport [KEY_POOL];
  logic [15:0] pool_lport [KEY_POOL];

  udp_port_demux_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always #4 clk = ~clk;

  function automatic updt_pkg::result_t make_result(logic [2:0] st, int slot,
                                                    logic [7:0] hd, logic [31:0] ip,
                                                    logic [15:0] port, bit wv,
                                                    logic [7:0] wid, bit fin);
    updt_pkg::result_t r;
    r.status      = st;
    r.slot_index  = slot[3:0];
    r.out_handle  = hd;
    r.sender_ip   = ip;
    r.sender_port = port;
    r.wake_valid  = wv;
    r.wake_id     = wid;
    r.last        = fin;
    return r;
  endfunction

  function automatic updt_pkg::request_t make_request(logic [2:0] cmd, logic [31:0] ip,
                                                      logic [15:0] rp, logic [15:0] lp,
                                                      logic [7:0] hd, logic [7:0] rq);
    updt_pkg::request_t r;
    r.command       = cmd;
    r.remote_ip     = ip;
    r.remote_port   = rp;
    r.local_port    = lp;
    r.packet_handle = hd;
    r.requester_id  = rq;
    return r;
  endfunction

  function automatic bit key_equal(int i, updt_pkg::request_t r);
    return ep_rip[i] == r.remote_ip && ep_rport[i] == r.remote_port &&
           ep_lport[i] == r.local_port;
  endfunction

  // work out the results of one accepted request and update the table copy
  function automatic void predict_request(updt_pkg::request_t r);
    int i;
    int p;
    int first;
    bit seen;
    bit hit;
    case (r.command)
      updt_pkg::CMD_REGISTER: begin
        for (i = 0; i < SLOTS; i++)
          if (ep_used[i] && key_equal(i, r)) begin
            pending_results.push_back(make_result(updt_pkg::ST_DUPLICATE, i, 0, 0, 0,
                                                  0, 0, 1));
            return;
          end
        for (i = 0; i < SLOTS; i++)
          if (!ep_used[i]) begin
            ep_used[i]    = 1'b1;
            ep_lport[i]   = r.local_port;
            ep_rport[i]   = r.remote_port;
            ep_rip[i]     = r.remote_ip;
            ring_count[i] = 0;
            ring_head[i]  = 0;
            ring_tail[i]  = 0;
            ep_waiting[i] = 1'b0;
            pending_results.push_back(make_result(updt_pkg::ST_OK, i, 0, 0, 0, 0, 0, 1));
            return;
          end
        pending_results.push_back(make_result(updt_pkg::ST_FULL, 0, 0, 0, 0, 0, 0, 1));
      end
      updt_pkg::CMD_RELEASE: begin
        for (i = 0; i < SLOTS; i++)
          if (ep_used[i] && !ep_waiting[i] && key_equal(i, r)) begin
            while (ring_count[i] > 0) begin
              p = ring_head[i];
              pending_results.push_back(make_result(updt_pkg::ST_FREED, i,
                                        ring_handle[i][p], ring_ip[i][p],
                                        ring_port[i][p], 0, 0, 0));
              ring_head[i] = (p + 1) % QUEUE_DEPTH;
              ring_count[i]--;
            end
            ep_used[i] = 1'b0;
            pending_results.push_back(make_result(updt_pkg::ST_OK, i, 0, 0, 0, 0, 0, 1));
            return;
          end
        pending_results.push_back(make_result(updt_pkg::ST_NO_MATCH, 0, 0, 0, 0,
                                              0, 0, 1));
      end
      updt_pkg::CMD_ARRIVAL: begin
        seen  = 1'b0;
        first = 0;
        if (r.packet_handle >= HANDLE_COUNT) begin
          pending_results.push_back(make_result(updt_pkg::ST_NO_MATCH, 0,
                                                r.packet_handle, 0, 0, 0, 0, 1));
          return;
        end
        for (i = 0; i < SLOTS; i++) begin
          if (!ep_used[i] || ep_lport[i] != r.local_port) continue;
          if (ep_rport[i] != 0 && ep_rport[i] != r.remote_port) continue;
          if (ep_rip[i] != 0 && ep_rip[i] != r.remote_ip) continue;
          if (!seen) begin
            seen  = 1'b1;
            first = i;
          end
          if (ring_count[i] < QUEUE_DEPTH) begin
            p = ring_tail[i];
            ring_handle[i][p] = r.packet_handle;
            ring_ip[i][p]     = r.remote_ip;
            ring_port[i][p]   = r.remote_port;
            ring_tail[i] = (p + 1) % QUEUE_DEPTH;
            ring_count[i]++;
            if (ep_waiting[i]) begin
              ep_waiting[i] = 1'b0;
              pending_results.push_back(make_result(updt_pkg::ST_OK, i, r.packet_handle,
                                                    0, 0, 1, ep_waiter[i], 1));
            end else begin
              pending_results.push_back(make_result(updt_pkg::ST_OK, i, r.packet_handle,
                                                    0, 0, 0, 0, 1));
            end
            return;
          end
        end
        pending_results.push_back(make_result(seen ? updt_pkg::ST_DROPPED :
                                              updt_pkg::ST_NO_MATCH, first,
                                              r.packet_handle, 0, 0, 0, 0, 1));
      end
      updt_pkg::CMD_RX_EXACT, updt_pkg::CMD_RX_ANY: begin
        for (i = 0; i < SLOTS; i++) begin
          if (!ep_used[i]) continue;
          if (r.command == updt_pkg::CMD_RX_EXACT) hit = key_equal(i, r);
          else hit = ep_rip[i] == 0 && ep_lport[i] == r.local_port;
          if (!hit) continue;
          if (ring_count[i] == 0) begin
            ep_waiting[i] = 1'b1;
            ep_waiter[i]  = r.requester_id;
            pending_results.push_back(make_result(updt_pkg::ST_WAITING, i, 0, 0, 0,
                                                  0, 0, 1));
          end else begin
            p = ring_head[i];
            pending_results.push_back(make_result(updt_pkg::ST_OK, i, ring_handle[i][p],
                                      ring_ip[i][p], ring_port[i][p], 0, 0, 1));
            ring_head[i] = (p + 1) % QUEUE_DEPTH;
            ring_count[i]--;
          end
          return;
        end
        pending_results.push_back(make_result(updt_pkg::ST_NO_MATCH, 0, 0, 0, 0,
                                              0, 0, 1));
      end
      default: ;
    endcase
  endfunction

  // random request, mostly over the key pool so that entries are hit
  function automatic updt_pkg::request_t random_request();
    updt_pkg::request_t r;
    int k;
    int pick;
    k    = $urandom_range(0, KEY_POOL - 1);
    pick = $urandom_range(0, 99);
    r = make_request(updt_pkg::CMD_ARRIVAL, pool_ip[k], pool_rport[k], pool_lport[k],
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    if (pick < 16) r.command = updt_pkg::CMD_REGISTER;
    else if (pick < 24) r.command = updt_pkg::CMD_RELEASE;
    else if (pick < 62) r.command = updt_pkg::CMD_ARRIVAL;
    else if (pick < 78) r.command = updt_pkg::CMD_RX_EXACT;
    else if (pick < 94) r.command = updt_pkg::CMD_RX_ANY;
    else r.command = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    // arrivals sometimes carry a concrete sender where the entry has a wildcard
    if (r.command == updt_pkg::CMD_ARRIVAL) begin
      if (pool_ip[k] == 0 && $urandom_range(0, 1)) r.remote_ip = $urandom();
      if (pool_rport[k] == 0 && $urandom_range(0, 1)) r.remote_port = 16'($urandom());
    end
    // some noise over the whole field ranges
    if ($urandom_range(0, 9) == 0) begin
      r.remote_ip   = $urandom();
      r.remote_port = 16'($urandom());
      r.local_port  = 16'($urandom());
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp_v, got_v);
      failures++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    updt_pkg::result_t exp_r;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result, actual %p", $time, res_data);
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(res_data.status));
        check_field("slot_index", 32'(exp_r.slot_index), 32'(res_data.slot_index));
        check_field("out_handle", 32'(exp_r.out_handle), 32'(res_data.out_handle));
        check_field("sender_ip", exp_r.sender_ip, res_data.sender_ip);
        check_field("sender_port", 32'(exp_r.sender_port), 32'(res_data.sender_port));
        check_field("wake_valid", 32'(exp_r.wake_valid), 32'(res_data.wake_valid));
        check_field("wake_id", 32'(exp_r.wake_id), 32'(res_data.wake_id));
        check_field("last", 32'(exp_r.last), 32'(res_data.last));
      end
    end
  end

  // receiver stalls: random bursts, one long hold-off, none at the end
  initial begin
    int n;
    int k;
    @(negedge clk);
    forever begin
      if (hold_off_now) begin
        res_stall = 1'b1;
        for (k = 0; k < 400; k++) @(negedge clk);
        res_stall = 1'b0;
        hold_off_now = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        res_stall = 1'b1;
        for (k = 0; k < n; k++) @(negedge clk);
        res_stall = 1'b0;
      end else begin
        @(negedge clk);
      end
    end
  end

  task automatic send_request(updt_pkg::request_t r, bit typed,
                              updt_pkg::result_t typed_res);
    int n;
    int k;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      req_valid = 1'b0;
      for (k = 0; k < n; k++) @(negedge clk);
    end
    req_valid = 1'b1;
    req_data  = r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_request(r);
    if (typed) begin
      void'(pending_results.pop_back());
      pending_results.push_back(typed_res);
    end
    @(negedge clk);
  endtask

  // stimulus
  initial begin
    int i;
    stim_row_t row;
    for (i = 0; i < SLOTS; i++) begin
      ep_used[i]    = 1'b0;
      ep_waiting[i] = 1'b0;
      ring_count[i] = 0;
      ring_head[i]  = 0;
      ring_tail[i]  = 0;
    end
    for (i = 0; i < KEY_POOL; i++) begin
      pool_ip[i]    = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom();
      pool_rport[i] = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom());
      pool_lport[i] = 16'(1000 + $urandom_range(0, 3));
    end
    pool_lport[0] = 16'd0;
    pool_lport[1] = 16'hffff;

    // directed table; typed rows carry their own expected results
    row.typed = 1'b1;
    row.req = make_request(updt_pkg::CMD_RX_EXACT, 1, 2, 3, 0, 0);
    row.res = make_result(updt_pkg::ST_NO_MATCH, 0, 0, 0, 0, 0, 0, 1);
    stim_table.push_back(row);
    row.req = make_request(updt_pkg::CMD_RELEASE, 0, 0, 0, 0, 0);
    stim_table.push_back(row);
    row.req = make_request(updt_pkg::CMD_ARRIVAL, '1, '1, '1, 8'hff, 0);
    row.res = make_result(updt_pkg::ST_NO_MATCH, 0, 8'hff, 0, 0, 0, 0, 1);
    stim_table.push_back(row);
    row.req = make_request(updt_pkg::CMD_REGISTER, '1, '1, '1, 0, 0);
    row.res = make_result(updt_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1);
    stim_table.push_back(row);
    row.res = make_result(updt_pkg::ST_DUPLICATE, 0, 0, 0, 0, 0, 0, 1);
    stim_table.push_back(row);
    row.req = make_request(updt_pkg::CMD_REGISTER, 0, 0, 0, 0, 0);
    row.res = make_result(updt_pkg::ST_OK, 1, 0, 0, 0, 0, 0, 1);
    stim_table.push_back(row);
    row.req = make_request(updt_pkg::CMD_RX_ANY, '1, '1, 0, 0, 8'hff);
    row.res = make_result(updt_pkg::ST_WAITING, 1, 0, 0, 0, 0, 0, 1);
    stim_table.push_back(row);
    // release skips the waiting entry
    row.req = make_request(updt_pkg::CMD_RELEASE, 0, 0, 0, 0, 0);
    row.res = make_result(updt_pkg::ST_NO_MATCH, 0, 0, 0, 0, 0, 0, 1);
    stim_table.push_back(row);
    row.req = make_request(updt_pkg::CMD_ARRIVAL, 32'h0a000001, 16'h1234, 0, 8'h00, 0);
    row.res = make_result(updt_pkg::ST_OK, 1, 0, 0, 0, 1, 8'hff, 1);
    stim_table.push_back(row);
    row.typed = 1'b0;
    for (i = 0; i < QUEUE_DEPTH + 1; i++) begin
      row.req = make_request(updt_pkg::CMD_ARRIVAL, '1, '1, '1, 8'(128 + i), 0);
      stim_table.push_back(row);
    end
    row.req = make_request(updt_pkg::CMD_RX_EXACT, '1, '1, '1, 0, 0);
    stim_table.push_back(row);
    row.req = make_request(updt_pkg::CMD_RX_ANY, 0, 0, 0, 0, 0);
    stim_table.push_back(row);
    row.req = make_request(CMD_UNUSED_HI, '1, '1, '1, '1, '1);
    stim_table.push_back(row);
    row.req = make_request(updt_pkg::CMD_RELEASE, '1, '1, '1, 0, 0);
    stim_table.push_back(row);
    row.req = make_request(updt_pkg::CMD_RELEASE, 0, 0, 0, 0, 0);
    stim_table.push_back(row);

    for (i = 0; i < 12; i++) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_table[j]) send_request(stim_table[j].req, stim_table[j].typed,
                                         stim_table[j].res);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 60) hold_off_now = 1'b1;
      if (i == QUIET_FROM) quiet_phase = 1'b1;
      send_request(random_request(), 1'b0, row.res);
    end
    req_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    for (i = 0; i < 60; i++) @(posedge clk);
    if (failures == 0) begin
      $display("[udp_port_demux_table] OK");
    end else begin
      $display("[udp_port_demux_table] ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("[udp_port_demux_table] ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/core/updt_pkg.sv
rtl/core/updt_ctrl.sv
rtl/core/updt_dp.sv
rtl/core/udp_port_demux_table.sv
rtl/core/updt_checker.sv
dv/udp_port_demux_table_test.sv
